### hdl/spr_pkg.sv
// Shared types and constants for the Sierpinski pattern pixel generator.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package spr_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int COORD_BITS_DEF     = 32;
  localparam int TERNARY_DIGITS_DEF = 21;

  // Fixed field widths
  localparam int PIXEL_BITS   = 14;
  localparam int RANDOM_BITS  = 32;
  localparam int HALF_BITS    = 16;
  localparam int SPAN_BITS    = 14;
  localparam int MOD_BITS     = SPAN_BITS + 1;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FRACTAL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_JUMP    = 2'd1;

  // Reset values of the configuration registers
  localparam logic [SPAN_BITS-1:0] JUMP_SPAN_RESET = 14'd100;

  // Pattern select codes
  typedef enum logic {
    FRACTAL_CARPET   = 1'b0,
    FRACTAL_TRIANGLE = 1'b1
  } spr_fractal_t;

  // Per-pixel classification flags carried down the digit chain
  typedef struct packed {
    logic done;   // outcome already known
    logic hit;    // pixel filled
  } spr_flags_t;

  // Status of the jump remainder unit
  typedef struct packed {
    logic busy;   // a jump is being computed or applied
    logic done;   // offsets valid this cycle
  } spr_jump_stat_t;

endpackage : spr_pkg

`default_nettype wire

### hdl/spr_jump_div.sv
// Remainder unit for a new pan destination: half mod (2*span+1), minus span.
// Restoring, one bit per cycle for both axes in parallel. Depends on spr_pkg.
`default_nettype none

module spr_jump_div
  import spr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [HALF_BITS-1:0] half_x,
  input  wire logic [HALF_BITS-1:0] half_y,
  input  wire logic [SPAN_BITS-1:0] span,
  output spr_jump_stat_t            stat,
  output logic [HALF_BITS-1:0]      offset_x,
  output logic [HALF_BITS-1:0]      offset_y
);

  localparam int CNT_BITS = $clog2(HALF_BITS);

  typedef enum logic [1:0] {
    JD_IDLE = 2'b01,
    JD_RUN  = 2'b10
  } jd_state_t;

  jd_state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [HALF_BITS-1:0]   sh_x_r, sh_x_nxt, sh_y_r, sh_y_nxt;
  logic [MOD_BITS-1:0]    rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [MOD_BITS-1:0]    mod_r, mod_nxt;
  logic [SPAN_BITS-1:0]   span_r, span_nxt;
  logic [HALF_BITS-1:0]   trial_x, trial_y;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial_x = {rem_x_r, sh_x_r[HALF_BITS-1]};
  assign trial_y = {rem_y_r, sh_y_r[HALF_BITS-1]};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    sh_x_nxt  = sh_x_r;
    sh_y_nxt  = sh_y_r;
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    mod_nxt   = mod_r;
    span_nxt  = span_r;
    case (state_r)
      JD_IDLE: begin
        if (start) begin
          state_nxt = JD_RUN;
          cnt_nxt   = CNT_BITS'(HALF_BITS - 1);
          sh_x_nxt  = half_x;
          sh_y_nxt  = half_y;
          rem_x_nxt = '0;
          rem_y_nxt = '0;
          mod_nxt   = {span, 1'b1};
          span_nxt  = span;
        end
      end
      JD_RUN: begin
        sh_x_nxt = {sh_x_r[HALF_BITS-2:0], 1'b0};
        sh_y_nxt = {sh_y_r[HALF_BITS-2:0], 1'b0};
        if (trial_x >= HALF_BITS'(mod_r)) begin
          rem_x_nxt = MOD_BITS'(trial_x - HALF_BITS'(mod_r));
        end else begin
          rem_x_nxt = MOD_BITS'(trial_x);
        end
        if (trial_y >= HALF_BITS'(mod_r)) begin
          rem_y_nxt = MOD_BITS'(trial_y - HALF_BITS'(mod_r));
        end else begin
          rem_y_nxt = MOD_BITS'(trial_y);
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = JD_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = JD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= JD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    sh_x_r  <= sh_x_nxt;
    sh_y_r  <= sh_y_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    mod_r   <= mod_nxt;
    span_r  <= span_nxt;
  end

  // Remainder minus span lies within +/- span, so 16 bits two's complement hold it
  assign offset_x  = HALF_BITS'(rem_x_r) - HALF_BITS'(span_r);
  assign offset_y  = HALF_BITS'(rem_y_r) - HALF_BITS'(span_r);
  assign stat.busy = (state_r != JD_IDLE) || done_r;
  assign stat.done = done_r;

endmodule : spr_jump_div

`default_nettype wire

### hdl/spr_entry.sv
// Entry pipeline: registers the pixel, adds the pan offset, takes magnitudes
// and settles triangle pixels. Three stages, valid/ready. Depends on spr_pkg.
`default_nettype none

module spr_entry
  import spr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire logic [PIXEL_BITS-1:0] pixel_x,
  input  wire logic [PIXEL_BITS-1:0] pixel_y,
  input  wire logic                  triangle,
  input  wire logic [COORD_BITS-1:0] view_x,
  input  wire logic [COORD_BITS-1:0] view_y,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output spr_flags_t                 dn_flags,
  output logic [COORD_BITS-1:0]      dn_a,
  output logic [COORD_BITS-1:0]      dn_b
);

  logic                  v0_r, v1_r, v2_r;
  logic                  rdy0, rdy1, rdy2;
  logic [PIXEL_BITS-1:0] px0_r, py0_r;
  logic                  tri0_r, tri1_r;
  logic [COORD_BITS-1:0] sx1_r, sy1_r;
  logic [COORD_BITS-1:0] mag_x, mag_y;
  spr_flags_t            flags2_r;
  logic [COORD_BITS-1:0] a2_r, b2_r;

  // A stage takes new data when empty or when its content moves on
  assign rdy2 = !v2_r || dn_ready;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  // Two's complement magnitude; the most negative value reads as unsigned
  assign mag_x = sx1_r[COORD_BITS-1] ? (~sx1_r + 1'b1) : sx1_r;
  assign mag_y = sy1_r[COORD_BITS-1] ? (~sy1_r + 1'b1) : sy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= up_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
    // Stage 0: pixel and pattern select
    if (rdy0) begin
      px0_r  <= pixel_x;
      py0_r  <= pixel_y;
      tri0_r <= triangle;
    end
    // Stage 1: wrapping sums with the pan position
    if (rdy1) begin
      sx1_r  <= COORD_BITS'(px0_r) + view_x;
      sy1_r  <= COORD_BITS'(py0_r) + view_y;
      tri1_r <= tri0_r;
    end
    // Stage 2: magnitudes for the carpet, final answer for the triangle
    if (rdy2) begin
      a2_r          <= mag_x;
      b2_r          <= mag_y;
      flags2_r.done <= tri1_r;
      flags2_r.hit  <= tri1_r && ((sx1_r & sy1_r) != '0);
    end
  end

  assign up_ready = rdy0;
  assign dn_valid = v2_r;
  assign dn_flags = flags2_r;
  assign dn_a     = a2_r;
  assign dn_b     = b2_r;

endmodule : spr_entry

`default_nettype wire

### hdl/spr_cell.sv
// One ternary digit cell of the carpet chain: checks the low base-3 digits
// of both magnitudes and hands the quotients on. Depends on spr_pkg.
`default_nettype none

module spr_cell
  import spr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire spr_flags_t            up_flags,
  input  wire logic [COORD_BITS-1:0] up_a,
  input  wire logic [COORD_BITS-1:0] up_b,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output spr_flags_t                 dn_flags,
  output logic [COORD_BITS-1:0]      dn_a,
  output logic [COORD_BITS-1:0]      dn_b
);

  // ceil(2^(N+1)/3): exact floor division by three for any N-bit value
  localparam logic [63:0] RECIP_W = ((64'd1 << (COORD_BITS + 1)) + 64'd2) / 64'd3;
  localparam logic [COORD_BITS-1:0] RECIP = RECIP_W[COORD_BITS-1:0];

  logic                    v_r;
  spr_flags_t              flags_r, flags_nxt;
  logic [COORD_BITS-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [2*COORD_BITS-1:0] prod_a, prod_b;
  logic [COORD_BITS-1:0]   q_a, q_b;
  logic [1:0]              r_a, r_b;
  logic                    ready;

  assign ready = !v_r || dn_ready;

  // Divide by three through the reciprocal; remainder from the low bits
  assign prod_a = up_a * RECIP;
  assign prod_b = up_b * RECIP;
  assign q_a    = COORD_BITS'(prod_a[2*COORD_BITS-1:COORD_BITS+1]);
  assign q_b    = COORD_BITS'(prod_b[2*COORD_BITS-1:COORD_BITS+1]);
  assign r_a    = up_a[1:0] - (q_a[1:0] + {q_a[0], 1'b0});
  assign r_b    = up_b[1:0] - (q_b[1:0] + {q_b[0], 1'b0});

  // Digit step: stop on a zero magnitude or on a pair of ones
  always_comb begin
    flags_nxt = up_flags;
    a_nxt     = q_a;
    b_nxt     = q_b;
    if (!up_flags.done) begin
      if ((up_a == '0) || (up_b == '0)) begin
        flags_nxt.done = 1'b1;
        flags_nxt.hit  = 1'b0;
      end else if ((r_a == 2'd1) && (r_b == 2'd1)) begin
        flags_nxt.done = 1'b1;
        flags_nxt.hit  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= up_valid;
    end
    if (ready) begin
      flags_r <= flags_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
    end
  end

  assign up_ready = ready;
  assign dn_valid = v_r;
  assign dn_flags = flags_r;
  assign dn_a     = a_r;
  assign dn_b     = b_r;

endmodule : spr_cell

`default_nettype wire

### hdl/sierpinski_pattern_pixel_generator.sv
// Sierpinski triangle / carpet pixel generator: top level with pan state,
// configuration registers, entry pipeline and the chain of digit cells.
// Depends on spr_pkg, spr_jump_div, spr_entry and spr_cell.
//
// Usage: one pixel coordinate per input transfer (in_valid/in_ready), one
// filled flag per output transfer (out_valid/out_ready), in order. Set
// in_frame_start on the first pixel of a frame: the pan position steps one
// unit toward its destination before that pixel is classified, or, when
// it has arrived, a new destination is drawn from in_random_word.
// Path: the entry pipeline, then one digit cell per ternary digit.
// Throughput: one pixel per cycle while the receiver keeps up. A new
// destination is computed by a bit-serial remainder unit; meanwhile pixels
// keep flowing, but a further frame-start pixel waits.
// Stalls: each pipeline stage holds while the next one is full, so a
// stalled receiver first fills the empty stages, then drops in_ready.
// Configuration: cfg_valid/cfg_ready writes, always ready; the user writes
// only while idle, which the block does not enforce. Reset (rst_n low,
// synchronous): pipeline empty, pan at zero, carpet mode, jump span 100.
`default_nettype none

module sierpinski_pattern_pixel_generator
  import spr_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TERNARY_DIGITS = TERNARY_DIGITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  // Pixel input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_frame_start,
  input  wire logic [RANDOM_BITS-1:0]   in_random_word,
  input  wire logic [PIXEL_BITS-1:0]    in_pixel_x,
  input  wire logic [PIXEL_BITS-1:0]    in_pixel_y,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_filled
);

  spr_fractal_t          fractal_r;
  logic [SPAN_BITS-1:0]  jump_span_r;
  logic [COORD_BITS-1:0] view_x_r, view_x_nxt, view_y_r, view_y_nxt;
  logic [COORD_BITS-1:0] target_x_r, target_x_nxt, target_y_r, target_y_nxt;
  logic                  accept, at_target, jump_start, entry_ready;
  spr_jump_stat_t        jump_stat;
  logic [HALF_BITS-1:0]  offset_x, offset_y;

  // Chain links: index 0 leaves the entry pipeline, the last is the output
  logic                  c_valid [TERNARY_DIGITS+1];
  logic                  c_ready [TERNARY_DIGITS+1];
  spr_flags_t            c_flags [TERNARY_DIGITS+1];
  logic [COORD_BITS-1:0] c_a     [TERNARY_DIGITS+1];
  logic [COORD_BITS-1:0] c_b     [TERNARY_DIGITS+1];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fractal_r   <= FRACTAL_CARPET;
      jump_span_r <= JUMP_SPAN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_FRACTAL: fractal_r   <= spr_fractal_t'(cfg_data[0]);
        CFG_IDX_JUMP:    jump_span_r <= cfg_data[SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A frame-start pixel waits while a new destination is still in flight
  assign in_ready   = entry_ready && !(jump_stat.busy && in_frame_start);
  assign accept     = in_valid && in_ready;
  assign at_target  = (view_x_r == target_x_r) && (view_y_r == target_y_r);
  assign jump_start = accept && in_frame_start && at_target;

  // Pan update: step toward the destination, or apply a finished jump
  always_comb begin
    view_x_nxt   = view_x_r;
    view_y_nxt   = view_y_r;
    target_x_nxt = target_x_r;
    target_y_nxt = target_y_r;
    if (accept && in_frame_start && !at_target) begin
      if ($signed(view_x_r) < $signed(target_x_r)) begin
        view_x_nxt = view_x_r + 1'b1;
      end else if ($signed(view_x_r) > $signed(target_x_r)) begin
        view_x_nxt = view_x_r - 1'b1;
      end
      if ($signed(view_y_r) < $signed(target_y_r)) begin
        view_y_nxt = view_y_r + 1'b1;
      end else if ($signed(view_y_r) > $signed(target_y_r)) begin
        view_y_nxt = view_y_r - 1'b1;
      end
    end
    if (jump_stat.done) begin
      target_x_nxt = target_x_r + COORD_BITS'($signed(offset_x));
      target_y_nxt = target_y_r + COORD_BITS'($signed(offset_y));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r   <= '0;
      view_y_r   <= '0;
      target_x_r <= '0;
      target_y_r <= '0;
    end else begin
      view_x_r   <= view_x_nxt;
      view_y_r   <= view_y_nxt;
      target_x_r <= target_x_nxt;
      target_y_r <= target_y_nxt;
    end
  end

  // New destination offsets from the random word
  spr_jump_div u_jump_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (jump_start),
    .half_x   (in_random_word[HALF_BITS-1:0]),
    .half_y   (in_random_word[RANDOM_BITS-1:HALF_BITS]),
    .span     (jump_span_r),
    .stat     (jump_stat),
    .offset_x (offset_x),
    .offset_y (offset_y)
  );

  // Pixel sums, magnitudes and triangle test
  spr_entry #(
    .COORD_BITS (COORD_BITS)
  ) u_entry (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid && in_ready),
    .up_ready (entry_ready),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .triangle (fractal_r == FRACTAL_TRIANGLE),
    .view_x   (view_x_r),
    .view_y   (view_y_r),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_flags (c_flags[0]),
    .dn_a     (c_a[0]),
    .dn_b     (c_b[0])
  );

  // Carpet digit chain, one ternary digit per cell
  for (genvar gi = 0; gi < TERNARY_DIGITS; gi++) begin : g_cell
    spr_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[gi]),
      .up_ready (c_ready[gi]),
      .up_flags (c_flags[gi]),
      .up_a     (c_a[gi]),
      .up_b     (c_b[gi]),
      .dn_valid (c_valid[gi+1]),
      .dn_ready (c_ready[gi+1]),
      .dn_flags (c_flags[gi+1]),
      .dn_a     (c_a[gi+1]),
      .dn_b     (c_b[gi+1])
    );
  end

  // The last cell's registers are the output register
  assign c_ready[TERNARY_DIGITS] = out_ready;
  assign out_valid  = c_valid[TERNARY_DIGITS];
  assign out_filled = c_flags[TERNARY_DIGITS].hit;

endmodule : sierpinski_pattern_pixel_generator

`default_nettype wire
